### hw/rtl/lpg_pkg.sv
// Shared widths, defaults and controller/datapath interface types for the line pixel generator.
package lpg_pkg;

    localparam int COORD_W         = 6;
    localparam int COLOR_W         = 24;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 40;
    localparam int M_FIELDS_W      = 2 * COORD_W + COLOR_W;
    localparam int DELTA_W         = COORD_W + 1;
    localparam int ERR_W           = COORD_W + 3;
    localparam int MATRIX_SIZE_DEF = 64;

    typedef struct packed {
        logic load;
        logic step;
    } lpg_cmd_t;

    typedef struct packed {
        logic last;
    } lpg_sts_t;

endpackage

### hw/rtl/lpg_ctrl.sv
// Controller state machine: sequences one line request at a time through the datapath.
module lpg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  lpg_pkg::lpg_sts_t sts,
    output lpg_pkg::lpg_cmd_t cmd
);
    import lpg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RUN);
    assign out_take = m_tvalid && m_tready;

    assign cmd.load = s_tvalid && s_tready;
    assign cmd.step = out_take && !sts.last;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_take && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/lpg_datapath.sv
// Datapath: endpoint clamping and ordering, Bresenham step unit and the pixel output register.
module lpg_datapath #(
    parameter int MATRIX_SIZE = lpg_pkg::MATRIX_SIZE_DEF
) (
    input  logic                          aclk,
    input  lpg_pkg::lpg_cmd_t             cmd,
    output lpg_pkg::lpg_sts_t             sts,
    input  logic [lpg_pkg::COORD_W-1:0]   start_x,
    input  logic [lpg_pkg::COORD_W-1:0]   start_y,
    input  logic [lpg_pkg::COORD_W-1:0]   end_x,
    input  logic [lpg_pkg::COORD_W-1:0]   end_y,
    input  logic [lpg_pkg::COLOR_W-1:0]   pixel_color,
    output logic [lpg_pkg::COORD_W-1:0]   pixel_x,
    output logic [lpg_pkg::COORD_W-1:0]   pixel_y,
    output logic [lpg_pkg::COLOR_W-1:0]   out_color,
    output logic                          last_pixel
);
    import lpg_pkg::*;

    localparam int COORD_LIM = (MATRIX_SIZE > 2 ** COORD_W) ? 2 ** COORD_W - 1
                                                            : MATRIX_SIZE - 1;
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_LIM[COORD_W-1:0];

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
        return (c > COORD_MAX) ? COORD_MAX : c;
    endfunction

    logic [COORD_W-1:0]      x_reg, y_reg, ex_reg, ey_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic [DELTA_W-1:0]      adx_reg, ady_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic                    sx_pos_reg, sy_pos_reg, xmaj_reg, last_reg;

    // Load path.
    logic [COORD_W-1:0]      cx1, cy1, cx2, cy2;
    logic [COORD_W-1:0]      x1s, y1s, x2s, y2s;
    logic [COORD_W-1:0]      dxa, dya;
    logic [DELTA_W-1:0]      adx_l, ady_l;
    logic                    axis, swap, sx_pos_l, sy_pos_l, xmaj_l;
    logic signed [ERR_W-1:0] err_l;

    // Step path.
    logic                    major_pos, step_minor, last_s;
    logic [DELTA_W-1:0]      major_d, minor_d;
    logic signed [ERR_W-1:0] err_s;
    logic [COORD_W-1:0]      x_s, y_s, x_inc, y_inc;

    always_comb begin
        cx1  = clamp(start_x);
        cy1  = clamp(start_y);
        cx2  = clamp(end_x);
        cy2  = clamp(end_y);
        axis = (cx1 == cx2) || (cy1 == cy2);
        // Axis-aligned lines are walked from the smaller coordinate upwards.
        swap = axis && ((cx1 == cx2) ? (cy1 > cy2) : (cx1 > cx2));
        x1s  = swap ? cx2 : cx1;
        y1s  = swap ? cy2 : cy1;
        x2s  = swap ? cx1 : cx2;
        y2s  = swap ? cy1 : cy2;
        sx_pos_l = x2s > x1s;
        sy_pos_l = y2s > y1s;
        dxa    = sx_pos_l ? (x2s - x1s) : (x1s - x2s);
        dya    = sy_pos_l ? (y2s - y1s) : (y1s - y2s);
        adx_l  = {dxa, 1'b0};
        ady_l  = {dya, 1'b0};
        xmaj_l = adx_l >= ady_l;
        err_l  = xmaj_l ? ($signed({2'b00, ady_l}) - $signed({3'b000, dxa}))
                        : ($signed({2'b00, adx_l}) - $signed({3'b000, dya}));
    end

    always_comb begin
        major_pos  = xmaj_reg ? sx_pos_reg : sy_pos_reg;
        major_d    = xmaj_reg ? adx_reg : ady_reg;
        minor_d    = xmaj_reg ? ady_reg : adx_reg;
        // On an exact tie the minor axis moves only when the major direction is positive.
        step_minor = (err_reg > 0) || ((err_reg == 0) && major_pos);
        err_s      = err_reg + $signed({2'b00, minor_d})
                     - (step_minor ? $signed({2'b00, major_d}) : '0);
        x_inc      = sx_pos_reg ? (x_reg + 1'b1) : (x_reg - 1'b1);
        y_inc      = sy_pos_reg ? (y_reg + 1'b1) : (y_reg - 1'b1);
        x_s        = (xmaj_reg || step_minor) ? x_inc : x_reg;
        y_s        = (!xmaj_reg || step_minor) ? y_inc : y_reg;
        last_s     = xmaj_reg ? (x_s == ex_reg) : (y_s == ey_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg      <= x1s;
            y_reg      <= y1s;
            ex_reg     <= x2s;
            ey_reg     <= y2s;
            color_reg  <= pixel_color;
            adx_reg    <= adx_l;
            ady_reg    <= ady_l;
            err_reg    <= err_l;
            sx_pos_reg <= sx_pos_l;
            sy_pos_reg <= sy_pos_l;
            xmaj_reg   <= xmaj_l;
            last_reg   <= xmaj_l ? (x1s == x2s) : (y1s == y2s);
        end else if (cmd.step) begin
            x_reg    <= x_s;
            y_reg    <= y_s;
            err_reg  <= err_s;
            last_reg <= last_s;
        end
    end

    assign sts.last   = last_reg;
    assign pixel_x    = x_reg;
    assign pixel_y    = y_reg;
    assign out_color  = color_reg;
    assign last_pixel = last_reg;

endmodule

### hw/rtl/line_pixel_generator_unit.sv
// The first pixel of a line is offered in the cycle after the request item is accepted.
// Throughput: one pixel per cycle while the output is taken; a line of N pixels (N at most
// MATRIX_SIZE, so at most 64) comes from the single Bresenham step unit, and no new request
// is accepted until the last pixel of the line has been taken.
// Reset (aresetn low, synchronous) returns the controller to idle and drops any line in flight.
module line_pixel_generator_unit #(
    parameter int MATRIX_SIZE = lpg_pkg::MATRIX_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_color[47:24]
    input  logic [lpg_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x[5:0], pixel_y[11:6], out_color[35:12], zeros[39:36]
    output logic [lpg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lpg_pkg::*;

    lpg_cmd_t           cmd;
    lpg_sts_t           sts;
    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [COLOR_W-1:0] out_color;

    lpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpg_datapath #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .sts         (sts),
        .start_x     (s_tdata[COORD_W-1:0]),
        .start_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .end_x       (s_tdata[3*COORD_W-1:2*COORD_W]),
        .end_y       (s_tdata[4*COORD_W-1:3*COORD_W]),
        .pixel_color (s_tdata[4*COORD_W+COLOR_W-1:4*COORD_W]),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_color   (out_color),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_color, pixel_y, pixel_x};

    // Only one line is in progress at a time.
    a_one_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while a line is still being emitted");

    a_req_to_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted line produced no first pixel");

    a_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("line ended before its last pixel");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after the last pixel");

endmodule
